// ----- rtl/mtfm_pkg.sv -----
// shared codes and types for the topic filter matcher
`timescale 1ns / 1ps
`default_nettype none

package mtfm_pkg;

	localparam int REQ_W  = 2;
	localparam int CHAR_W = 8;

	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TOPIC  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_END    = 2'd3;

	localparam logic [CHAR_W-1:0] CH_MULTI  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_SINGLE = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;

	typedef struct packed {
		logic match;
		logic filter_overflow;
	} verdict_t;

endpackage

`default_nettype wire

// ----- rtl/mqtt_topic_filter_match_top.sv -----
// top level of the topic filter matcher: stream ports, filter memory, walk, result register
//
// channel  dir  tdata                                        tuser
// s_*      in   [7:0] char_value                             [1:0] req_type
// m_*      out  [0] match, [1] filter_overflow, [7:2] zero   -
//
// one word per cycle on the input while s_tready is high; each word passes through the walk
// with one filter memory read (next char kept registered) and a few compares
// an end-of-topic word gives its result word on m_* the cycle after acceptance
// s_tready drops only while a result word waits on m_* with m_tready low
// reset clears filter length, walk state and the result valid flag; filter memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module mqtt_topic_filter_match_top #(
	parameter int MAX_FILTER = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] char_value
	input  wire logic [1:0] s_tuser,  // [1:0] req_type
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata   // [0] match, [1] filter_overflow
);

	localparam int AW = $clog2(MAX_FILTER);
	localparam int LW = $clog2(MAX_FILTER + 1);

	logic                        acc;
	logic                        we;
	logic [AW-1:0]               waddr, raddr;
	logic [mtfm_pkg::CHAR_W-1:0] wdata, rdata;
	logic                        verdict_valid;
	mtfm_pkg::verdict_t          verdict;
	logic                        m_valid_q;
	mtfm_pkg::verdict_t          m_data_q;

	assign s_tready = !m_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	mtfm_store #(
		.DEPTH(MAX_FILTER),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	mtfm_walk #(
		.MAX_FILTER(MAX_FILTER),
		.AW        (AW),
		.LW        (LW)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.req          (s_tuser),
		.ch           (s_tdata),
		.rdata        (rdata),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.raddr        (raddr),
		.verdict_valid(verdict_valid),
		.verdict      (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (verdict_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (verdict_valid) begin
			m_data_q <= verdict;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, m_data_q.filter_overflow, m_data_q.match};

	a_hold_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |-> !acc)
		else $error("word accepted while result word stalled");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> m_valid_q)
		else $error("result word dropped while stalled");

	a_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> $stable(m_data_q))
		else $error("result word changed while stalled");

endmodule

`default_nettype wire

// ----- rtl/mtfm_store.sv -----
// filter character memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module mtfm_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [mtfm_pkg::CHAR_W-1:0] wdata,
	input  wire logic [AW-1:0]               raddr,
	output logic      [mtfm_pkg::CHAR_W-1:0] rdata
);

	logic [mtfm_pkg::CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// same-address write is forwarded
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mtfm_walk.sv -----
// filter load and wildcard walk state, with read address for the next filter char
`timescale 1ns / 1ps
`default_nettype none

module mtfm_walk #(
	parameter int MAX_FILTER = 64,
	parameter int AW         = 6,
	parameter int LW         = 7
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        acc,
	input  wire logic [mtfm_pkg::REQ_W-1:0]  req,
	input  wire logic [mtfm_pkg::CHAR_W-1:0] ch,
	input  wire logic [mtfm_pkg::CHAR_W-1:0] rdata,
	output logic                             we,
	output logic      [AW-1:0]               waddr,
	output logic      [mtfm_pkg::CHAR_W-1:0] wdata,
	output logic      [AW-1:0]               raddr,
	output logic                             verdict_valid,
	output mtfm_pkg::verdict_t               verdict
);

	logic [LW-1:0]               len_q, len_n;
	logic [LW-1:0]               pos_q, pos_n, pos_w, pos_inc;
	logic [mtfm_pkg::CHAR_W-1:0] cur_q, cur_n, cur_w;
	logic [mtfm_pkg::CHAR_W-1:0] first_q, first_n;
	logic [mtfm_pkg::CHAR_W-1:0] held_q, held_n;
	logic                        held_v_q, held_v_n;
	logic                        dec_q, dec_n;
	logic                        val_q, val_n;
	logic                        ovf_q, ovf_n;
	logic                        do_walk, slash, avail, adv, step_dec, step_val, m;

	assign slash   = (req == mtfm_pkg::REQ_TOPIC) && (ch == mtfm_pkg::CH_SLASH);
	assign do_walk = acc && held_v_q && !dec_q &&
		((req == mtfm_pkg::REQ_TOPIC) || (req == mtfm_pkg::REQ_END));
	assign avail   = pos_q < len_q;

	// one walk step on the held char
	always_comb begin
		adv      = 1'b0;
		step_dec = dec_q;
		step_val = val_q;
		if (do_walk) begin
			if (!avail) begin
				step_dec = 1'b1;
				step_val = 1'b0;
			end else if (cur_q == mtfm_pkg::CH_MULTI) begin
				step_dec = 1'b1;
				step_val = 1'b1;
			end else if (cur_q == held_q) begin
				adv = 1'b1;
			end else if (cur_q == mtfm_pkg::CH_SINGLE) begin
				adv = slash;
			end else begin
				step_dec = 1'b1;
				step_val = 1'b0;
			end
		end
	end

	assign pos_w = pos_q + LW'(adv);
	assign cur_w = adv ? rdata : cur_q;

	always_comb begin
		if (step_dec) begin
			m = step_val;
		end else begin
			m = !((pos_w < len_q) && (cur_w != mtfm_pkg::CH_SINGLE));
		end
		if (ovf_q) begin
			m = 1'b0;
		end
	end

	always_comb begin
		len_n         = len_q;
		pos_n         = pos_q;
		cur_n         = cur_q;
		first_n       = first_q;
		held_n        = held_q;
		held_v_n      = held_v_q;
		dec_n         = dec_q;
		val_n         = val_q;
		ovf_n         = ovf_q;
		we            = 1'b0;
		waddr         = len_q[AW-1:0];
		wdata         = ch;
		verdict_valid = 1'b0;
		if (acc) begin
			case (req)
				mtfm_pkg::REQ_CLEAR: begin
					len_n = '0;
					ovf_n = 1'b0;
				end
				mtfm_pkg::REQ_APPEND: begin
					if (len_q < LW'(MAX_FILTER)) begin
						we    = 1'b1;
						len_n = len_q + LW'(1);
						if (len_q == '0) begin
							first_n = ch;
						end
					end else begin
						ovf_n = 1'b1;
					end
				end
				mtfm_pkg::REQ_TOPIC: begin
					pos_n    = pos_w;
					cur_n    = cur_w;
					dec_n    = step_dec;
					val_n    = step_val;
					held_n   = ch;
					held_v_n = 1'b1;
				end
				mtfm_pkg::REQ_END: begin
					verdict_valid = 1'b1;
				end
				default: begin
					verdict_valid = 1'b0;
				end
			endcase
			if (req != mtfm_pkg::REQ_TOPIC) begin
				pos_n    = '0;
				cur_n    = first_n;
				held_n   = '0;
				held_v_n = 1'b0;
				dec_n    = 1'b0;
				val_n    = 1'b0;
			end
		end
	end

	assign verdict.match           = m;
	assign verdict.filter_overflow = ovf_q;

	// keep the char after the current one in the read register
	assign pos_inc = pos_n + LW'(1);
	assign raddr   = pos_inc[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			pos_q    <= '0;
			held_v_q <= 1'b0;
			dec_q    <= 1'b0;
			val_q    <= 1'b0;
			ovf_q    <= 1'b0;
			held_q   <= '0;
		end else begin
			len_q    <= len_n;
			pos_q    <= pos_n;
			held_v_q <= held_v_n;
			dec_q    <= dec_n;
			val_q    <= val_n;
			ovf_q    <= ovf_n;
			held_q   <= held_n;
		end
	end

	always_ff @(posedge clk) begin
		cur_q   <= cur_n;
		first_q <= first_n;
	end

	a_pos_in_filter: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= len_q)
		else $error("walk position beyond filter length");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LW'(MAX_FILTER)))
		else $error("overflow flagged with filter not full");

	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req == mtfm_pkg::REQ_END)) |=> (!held_v_q && !dec_q && (pos_q == '0)))
		else $error("walk not restarted after end of topic");

endmodule

`default_nettype wire
